FILE: rtl/lkcm_pkg.sv
// lkcm_pkg: shared types, constants and keyword tables of the line keyword command matcher
// no dependencies
package lkcm_pkg;

  localparam int unsigned LINE_BYTES = 32;
  localparam int unsigned CNT_W      = $clog2(LINE_BYTES);

  localparam int unsigned KEY_COUNT = 7;
  localparam int unsigned KEY_MAX   = 8;
  localparam int unsigned POS_W     = $clog2(KEY_MAX);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  localparam logic [2:0] CODE_NORMAL  = 3'd0;
  localparam logic [2:0] CODE_BLINK   = 3'd1;
  localparam logic [2:0] CODE_HAPPY   = 3'd2;
  localparam logic [2:0] CODE_SLEEP   = 3'd3;
  localparam logic [2:0] CODE_SAD     = 3'd4;
  localparam logic [2:0] CODE_PING    = 3'd5;
  localparam logic [2:0] CODE_HELP    = 3'd6;
  localparam logic [2:0] CODE_UNKNOWN = 3'd7;

  // keywords, upper case, zero padded
  localparam logic [7:0] KEY_TEXT [KEY_COUNT][KEY_MAX] = '{
    '{"N", "O", "R", "M", "A", "L", 8'h00, 8'h00},
    '{"B", "L", "I", "N", "K", 8'h00, 8'h00, 8'h00},
    '{"H", "A", "P", "P", "Y", 8'h00, 8'h00, 8'h00},
    '{"S", "L", "E", "E", "P", 8'h00, 8'h00, 8'h00},
    '{"S", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "I", "N", "G", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "E", "L", "P", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KEY_LEN [KEY_COUNT] = '{3'd6, 3'd5, 3'd5, 3'd5, 3'd3, 3'd4, 3'd4};

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_ZERO,
    KIND_EOL
  } lkcm_kind_e;

  typedef struct packed {
    lkcm_kind_e kind;
    logic [7:0] ch;
  } lkcm_item_t;

  typedef struct packed {
    logic       push;
    lkcm_item_t item;
  } lkcm_push_t;

endpackage

FILE: rtl/lkcm_if.sv
// lkcm_in_if / lkcm_out_if: valid-ready channels for received bytes and command codes
// no dependencies
interface lkcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface lkcm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] command_code;

  modport source (output valid, output command_code, input ready);
  modport sink   (input valid, input command_code, output ready);
endinterface

FILE: rtl/line_keyword_command_matcher.sv
// line_keyword_command_matcher: top level, front classifier, queue and matcher back end
// depends on lkcm_pkg, lkcm_if, lkcm_front, lkcm_queue, lkcm_back
//
// Takes one received byte per beat and gathers bytes into lines ended by CR or LF; each
// non-empty line yields one command code (0 normal .. 6 help, 7 unknown), compared with
// lower case folded to upper case and cut at the first zero byte. A line reaching
// LINE_BYTES bytes is dropped with that byte and gives no code. One byte is accepted every
// cycle while the output side keeps up; the two-entry queue lets a stalled result hold the
// back end while the front keeps taking bytes until the queue fills. A command is valid on
// the output after its line end is accepted: the byte is written into the queue, waits at
// its head until the back end pops it, then the back end registers the code.
module line_keyword_command_matcher (
  input  logic clk_i,
  input  logic rst_ni,
  lkcm_in_if.sink     in_i,
  lkcm_out_if.source  out_o
);
  import lkcm_pkg::*;

  lkcm_push_t push;
  lkcm_item_t item;
  logic       q_full, q_empty, pop;

  lkcm_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  lkcm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .item_o  (item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  lkcm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

FILE: rtl/lkcm_front.sv
// lkcm_front: accepts received bytes, classifies them and folds case before queueing
// depends on lkcm_pkg and lkcm_in_if
module lkcm_front (
  lkcm_in_if.sink           in_i,
  input  logic              q_full_i,
  output lkcm_pkg::lkcm_push_t push_o
);
  import lkcm_pkg::*;

  logic [7:0] b;

  assign b          = in_i.data_byte;
  assign in_i.ready = !q_full_i;

  always_comb begin
    push_o.push      = in_i.valid && !q_full_i;
    push_o.item.ch   = b;
    push_o.item.kind = KIND_CHAR;
    if (b == CHAR_CR || b == CHAR_LF) begin
      push_o.item.kind = KIND_EOL;
    end else if (b == CHAR_NUL) begin
      push_o.item.kind = KIND_ZERO;
    end else if (b >= CHAR_LOW_A && b <= CHAR_LOW_Z) begin
      push_o.item.ch = b - CASE_DIFF;
    end
  end

endmodule

FILE: rtl/lkcm_queue.sv
// lkcm_queue: short fifo of classified beats between front and back
// depends on lkcm_pkg
module lkcm_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lkcm_pkg::lkcm_push_t push_i,
  input  logic                 pop_i,
  output lkcm_pkg::lkcm_item_t item_o,
  output logic                 empty_o,
  output logic                 full_o
);
  import lkcm_pkg::*;

  lkcm_item_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a push");

endmodule

FILE: rtl/lkcm_back.sv
// lkcm_back: line state, per-keyword match flags and registered command output
// depends on lkcm_pkg and lkcm_out_if
module lkcm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lkcm_pkg::lkcm_item_t item_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  lkcm_out_if.source           out_o
);
  import lkcm_pkg::*;

  logic [CNT_W-1:0]     line_count_q, line_count_d;
  logic [CNT_W-1:0]     text_count_q, text_count_d;
  logic                 zero_seen_q, zero_seen_d;
  logic [KEY_COUNT-1:0] flags_q, flags_d;
  logic                 out_valid_q, out_valid_d;
  logic [2:0]           code_q, code_d;
  logic [2:0]           match_code;
  logic [POS_W-1:0]     pos;

  assign pop_o              = !empty_i && (!out_valid_q || out_o.ready);
  assign out_o.valid        = out_valid_q;
  assign out_o.command_code = code_q;
  assign pos                = text_count_q[POS_W-1:0];

  always_comb begin
    match_code = CODE_UNKNOWN;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (flags_q[k] && text_count_q == CNT_W'(KEY_LEN[k])) begin
        match_code = 3'(k);
      end
    end
  end

  always_comb begin
    line_count_d = line_count_q;
    text_count_d = text_count_q;
    zero_seen_d  = zero_seen_q;
    flags_d      = flags_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    code_d       = code_q;
    if (pop_o) begin
      if (item_i.kind == KIND_EOL) begin
        if (line_count_q != '0) begin
          out_valid_d  = 1'b1;
          code_d       = match_code;
          line_count_d = '0;
          text_count_d = '0;
          zero_seen_d  = 1'b0;
          flags_d      = '1;
        end
      end else if (line_count_q >= CNT_W'(LINE_BYTES - 1)) begin
        line_count_d = '0;
        text_count_d = '0;
        zero_seen_d  = 1'b0;
        flags_d      = '1;
      end else begin
        line_count_d = line_count_q + 1'b1;
        if (!zero_seen_q) begin
          if (item_i.kind == KIND_ZERO) begin
            zero_seen_d = 1'b1;
          end else begin
            for (int k = 0; k < KEY_COUNT; k++) begin
              if (text_count_q >= CNT_W'(KEY_LEN[k]) || KEY_TEXT[k][pos] != item_i.ch) begin
                flags_d[k] = 1'b0;
              end
            end
            text_count_d = text_count_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= '0;
      text_count_q <= '0;
      zero_seen_q  <= 1'b0;
      flags_q      <= '1;
      out_valid_q  <= 1'b0;
    end else begin
      line_count_q <= line_count_d;
      text_count_q <= text_count_d;
      zero_seen_q  <= zero_seen_d;
      flags_q      <= flags_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_count_q <= CNT_W'(LINE_BYTES - 1))
    else $error("line count past line limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_count_q <= line_count_q)
    else $error("compared text longer than line");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && item_i.kind == KIND_EOL && line_count_q != '0) |=> out_valid_q)
    else $error("line end gave no command");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !pop_o)
    else $error("pop while result stalled");

endmodule

FILE: tb/line_keyword_command_matcher_tb.sv
`timescale 1ns / 1ps
// line_keyword_command_matcher_tb: drives received bytes into the matcher, predicts command codes
// depends on lkcm_pkg, lkcm_if and the line_keyword_command_matcher rtl
module line_keyword_command_matcher_tb;
  import lkcm_pkg::*;

  class command_scoreboard;
    string      keywords [KEY_COUNT];
    logic [2:0] key_codes [KEY_COUNT];
    logic [2:0] expected_codes [$];
    int         line_len;
    int         text_len;
    bit         nul_seen;
    logic [6:0] live_keys;
    int         errors;

    function new();
      keywords  = '{"NORMAL", "BLINK", "HAPPY", "SLEEP", "SAD", "PING", "HELP"};
      key_codes = '{CODE_NORMAL, CODE_BLINK, CODE_HAPPY, CODE_SLEEP, CODE_SAD, CODE_PING,
                    CODE_HELP};
      errors    = 0;
      clear_line();
    endfunction

    function void clear_line();
      line_len  = 0;
      text_len  = 0;
      nul_seen  = 0;
      live_keys = '1;
    endfunction

    // lowest code wins on a tie
    function logic [2:0] line_code();
      logic [2:0] code;
      code = CODE_UNKNOWN;
      for (int i = KEY_COUNT - 1; i >= 0; i--) begin
        if (live_keys[i] && keywords[i].len() == text_len) code = key_codes[i];
      end
      return code;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] c;
      if (b == CHAR_CR || b == CHAR_LF) begin
        if (line_len != 0) begin
          expected_codes.push_back(line_code());
          clear_line();
        end
        return;
      end
      if (line_len >= LINE_BYTES - 1) begin
        clear_line();
        return;
      end
      line_len++;
      if (nul_seen) return;
      if (b == CHAR_NUL) begin
        nul_seen = 1;
        return;
      end
      c = b;
      if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) c = c - CASE_DIFF;
      for (int i = 0; i < KEY_COUNT; i++) begin
        if (text_len >= keywords[i].len() || keywords[i][text_len] != c) live_keys[i] = 1'b0;
      end
      text_len++;
    endfunction

    function void check_code(logic [2:0] got);
      logic [2:0] want;
      if (expected_codes.size() == 0) begin
        $display("%0t: unexpected command_code %0d", $time, got);
        errors++;
        return;
      end
      want = expected_codes.pop_front();
      if (got !== want) begin
        $display("%0t: command_code mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_codes.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lkcm_in_if  in_if ();
  lkcm_out_if out_if ();

  line_keyword_command_matcher i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  command_scoreboard sb = new();

  int bytes_sent;
  bit steady;
  bit hold_req;
  bit hold_done;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 21) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_word(input string w, input bit mix_case);
    logic [7:0] c;
    for (int j = 0; j < w.len(); j++) begin
      c = w[j];
      if (mix_case && $urandom_range(1)) c = c | CASE_DIFF;
      send_byte(c);
    end
  endtask

  // any byte that does not end the line
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == CHAR_CR || b == CHAR_LF) b = b ^ 8'h40;
    return b;
  endfunction

  task automatic send_eol();
    case ($urandom_range(3))
      0: send_byte(CHAR_CR);
      1: send_byte(CHAR_LF);
      2: begin
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
      end
      default: begin
        send_byte(CHAR_LF);
        send_byte(CHAR_CR);
      end
    endcase
  endtask

  task automatic send_random_line();
    int    r;
    int    n;
    string w;
    r = $urandom_range(99);
    w = sb.keywords[$urandom_range(KEY_COUNT - 1)];
    if (r < 50) begin
      send_word(w, 1'b1);
    end else if (r < 60) begin
      send_word(w, 1'b1);
      send_byte(CHAR_NUL);
      n = $urandom_range(5);
      repeat (n) send_byte(text_byte());
    end else if (r < 70) begin
      case ($urandom_range(2))
        0: begin
          n = $urandom_range(w.len() - 1);
          for (int j = 0; j < w.len(); j++) begin
            if (j == n) send_byte(text_byte());
            else send_byte(w[j]);
          end
        end
        1: send_word(w.substr(0, w.len() - 2), 1'b1);
        default: begin
          send_word(w, 1'b1);
          send_byte(text_byte());
        end
      endcase
    end else if (r < 76) begin
      // empty line only
    end else if (r < 88) begin
      n = $urandom_range(12);
      repeat (n) send_byte(8'($urandom_range(255)));
    end else if (r < 94) begin
      // around the line length limit
      n = $urandom_range(LINE_BYTES + 8, LINE_BYTES - 4);
      repeat (n) send_byte(text_byte());
    end else begin
      n = $urandom_range(3, 1);
      repeat (n) send_byte(CHAR_NUL);
      if (r < 97) send_word(w, 1'b1);
    end
    send_eol();
  endtask

  // result side, with random stalls and one long hold
  initial begin
    int hold_left;
    hold_left    = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) sb.check_code(out_if.command_code);
      if (hold_req) begin
        hold_left = 60;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady || ($urandom_range(99) >= 21);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    bytes_sent      = 0;
    steady          = 1'b0;
    hold_req        = 1'b0;
    hold_done       = 1'b0;
    rst_ni          = 1'b0;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= 8'h00;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed lines: case folding, zero byte, zero-only line, high bytes, near miss
    send_word("nOrMaL", 1'b0);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_word("sad", 1'b0);
    send_byte(CHAR_NUL);
    send_word("q", 1'b0);
    send_byte(CHAR_LF);
    send_byte(CHAR_NUL);
    send_byte(CHAR_LF);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(CHAR_CR);
    send_word("HELPS", 1'b0);
    send_byte(CHAR_LF);

    while (bytes_sent < 830) begin
      steady = (bytes_sent >= 350) && (bytes_sent < 500);
      if (!hold_done && bytes_sent >= 200) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      send_random_line();
    end
    steady = 1'b0;
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lkcm_pkg.sv
rtl/lkcm_if.sv
rtl/lkcm_front.sv
rtl/lkcm_queue.sv
rtl/lkcm_back.sv
rtl/line_keyword_command_matcher.sv
tb/line_keyword_command_matcher_tb.sv
